// ----- hdl/cspt_pkg.sv -----
// ----------------------------------------------------------------------------
// cspt_pkg
// Shared sizes, codes and control structs of the CA slot PID/CAID table.
// ----------------------------------------------------------------------------
package cspt_pkg;

  localparam int SLOT_COUNT   = 3;
  localparam int PID_ENTRIES  = 16;
  localparam int CAID_ENTRIES = 16;

  localparam int MAX_ENTRIES = (PID_ENTRIES > CAID_ENTRIES) ? PID_ENTRIES : CAID_ENTRIES;
  localparam int PID_DEPTH   = SLOT_COUNT * PID_ENTRIES;
  localparam int CAID_DEPTH  = SLOT_COUNT * CAID_ENTRIES;
  localparam int PID_AW      = (PID_DEPTH > 1) ? $clog2(PID_DEPTH) : 1;
  localparam int CAID_AW     = (CAID_DEPTH > 1) ? $clog2(CAID_DEPTH) : 1;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam logic [3:0] SLOT_LIMIT = 4'(SLOT_COUNT);
  localparam logic [2:0] SLOT_LAST  = 3'(SLOT_COUNT - 1);

  // operation codes
  localparam logic [2:0] OP_FIND         = 3'd0;
  localparam logic [2:0] OP_ADD          = 3'd1;
  localparam logic [2:0] OP_DEL          = 3'd2;
  localparam logic [2:0] OP_CLEAR        = 3'd3;
  localparam logic [2:0] OP_CAID_BY_PID  = 3'd4;
  localparam logic [2:0] OP_SLOT_BY_KEYS = 3'd5;

  // list selectors
  localparam logic [1:0] LIST_PID   = 2'd0;
  localparam logic [1:0] LIST_CAID  = 2'd1;
  localparam logic [1:0] LIST_CAPID = 2'd2;
  localparam logic [1:0] LIST_ALL   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SLOT = 2'd1;
  localparam logic [1:0] ST_NO_MATCH = 2'd2;

  typedef struct packed {
    logic load;
    logic start_scan;
    logic issue;
    logic next_slot;
    logic capture;
  } cspt_cmd_t;

  typedef struct packed {
    logic skip_scan;
    logic idx_last;
    logic multi_slot;
    logic slot_done;
    logic slot_last;
    logic out_free;
  } cspt_stat_t;

endpackage

// ----- hdl/cspt_if.sv -----
// ----------------------------------------------------------------------------
// cspt_if
// Request and response channels of the CA slot PID/CAID table.
// ----------------------------------------------------------------------------
interface cspt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [2:0]  slot;
  logic [1:0]  list_sel;
  logic [15:0] key;
  logic [15:0] second_key;

  modport source (output valid, op, slot, list_sel, key, second_key, input ready);
  modport sink (input valid, op, slot, list_sel, key, second_key, output ready);
endinterface

interface cspt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        flag;
  logic [15:0] value_out;
  logic [2:0]  slot_out;

  modport source (output valid, status, flag, value_out, slot_out, input ready);
  modport sink (input valid, status, flag, value_out, slot_out, output ready);
endinterface

// ----- hdl/cspt_ram.sv -----
// ----------------------------------------------------------------------------
// cspt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cspt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 48,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/cspt_dp.sv -----
// ----------------------------------------------------------------------------
// cspt_dp
// Table datapath: list RAMs, entry valid bits, scan compare and result regs.
// ----------------------------------------------------------------------------
module cspt_dp import cspt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cspt_cmd_t   cmd,
  output cspt_stat_t  stat,
  input  logic [2:0]  op,
  input  logic [2:0]  slot,
  input  logic [1:0]  list_sel,
  input  logic [15:0] key,
  input  logic [15:0] second_key,
  input  logic        rsp_ready,
  output logic        rsp_valid,
  output logic [1:0]  status,
  output logic        flag,
  output logic [15:0] value_out,
  output logic [2:0]  slot_out
);

  // item fields
  logic [2:0]  op_r;
  logic [2:0]  slot_r;
  logic [1:0]  sel_r;
  logic [15:0] key_r;
  logic [15:0] key2_r;

  // scan issue and compare stage
  logic [CNT_W-1:0] idx;
  logic [IDX_W-1:0] idx_i;
  logic             in_p, in_c;
  logic             issued;
  logic [IDX_W-1:0] issued_idx;
  logic             in_p_q, in_c_q;
  logic             pid_v_q, caid_v_q, capid_v_q;

  // accumulated scan results for the current slot
  logic             pid_hit;
  logic [IDX_W-1:0] pid_idx;
  logic             caid_hit;
  logic             sel_hit;
  logic             empty_found;
  logic [IDX_W-1:0] empty_idx;
  logic [15:0]      caid_first;

  // entry valid bits; an entry that is not valid reads as zero
  logic [PID_DEPTH-1:0]  pid_vld;
  logic [CAID_DEPTH-1:0] caid_vld;
  logic [PID_DEPTH-1:0]  capid_vld;

  logic [PID_AW-1:0]  pid_raddr, pid_waddr, del_addr;
  logic [CAID_AW-1:0] caid_raddr, caid_waddr;
  logic [15:0]        pid_q, caid_q, capid_q;
  logic [15:0]        pid_val, caid_val, capid_val, caid_key;
  logic               pid_eq, caid_eq, capid_eq, sel_eq, sel_zero;

  logic range_err, add_ok, cap_ok, add_we;
  logic pid_we, caid_we, capid_we, del_clr, clr_op;
  logic clr_pid, clr_caid, clr_capid;

  logic [1:0]  status_next;
  logic        flag_next;
  logic [15:0] value_next;
  logic [2:0]  slot_out_next;

  assign idx_i = idx[IDX_W-1:0];
  assign in_p  = idx < CNT_W'(PID_ENTRIES);
  assign in_c  = idx < CNT_W'(CAID_ENTRIES);

  assign pid_raddr  = PID_AW'(slot_r * PID_ENTRIES + idx_i);
  assign caid_raddr = CAID_AW'(slot_r * CAID_ENTRIES + idx_i);
  assign pid_waddr  = PID_AW'(slot_r * PID_ENTRIES + empty_idx);
  assign caid_waddr = CAID_AW'(slot_r * CAID_ENTRIES + empty_idx);
  assign del_addr   = PID_AW'(slot_r * PID_ENTRIES + pid_idx);

  assign range_err = (op_r <= OP_CLEAR) && ({1'b0, slot_r} >= SLOT_LIMIT);
  assign add_ok    = !sel_hit && empty_found;
  assign cap_ok    = cmd.capture && !range_err;
  assign add_we    = cap_ok && (op_r == OP_ADD) && add_ok;
  assign pid_we    = add_we && (sel_r == LIST_PID);
  assign caid_we   = add_we && (sel_r == LIST_CAID);
  assign capid_we  = add_we && (sel_r == LIST_CAPID);
  assign del_clr   = cap_ok && (op_r == OP_DEL) && pid_hit;
  assign clr_op    = cap_ok && (op_r == OP_CLEAR);
  assign clr_pid   = clr_op && ((sel_r == LIST_PID) || (sel_r == LIST_ALL));
  assign clr_caid  = clr_op && ((sel_r == LIST_CAID) || (sel_r == LIST_ALL));
  assign clr_capid = clr_op && ((sel_r == LIST_CAPID) || (sel_r == LIST_ALL));

  cspt_ram #(.WIDTH(16), .DEPTH(PID_DEPTH)) u_pid_ram (
    .clk   (clk),
    .we    (pid_we),
    .waddr (pid_waddr),
    .wdata (key_r),
    .raddr (pid_raddr),
    .rdata (pid_q)
  );

  cspt_ram #(.WIDTH(16), .DEPTH(CAID_DEPTH)) u_caid_ram (
    .clk   (clk),
    .we    (caid_we),
    .waddr (caid_waddr),
    .wdata (key_r),
    .raddr (caid_raddr),
    .rdata (caid_q)
  );

  cspt_ram #(.WIDTH(16), .DEPTH(PID_DEPTH)) u_capid_ram (
    .clk   (clk),
    .we    (capid_we),
    .waddr (pid_waddr),
    .wdata (key_r),
    .raddr (pid_raddr),
    .rdata (capid_q)
  );

  // item capture and slot stepping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op;
      sel_r  <= list_sel;
      key_r  <= key;
      key2_r <= second_key;
      // cross-slot searches start at slot 0
      slot_r <= ((op == OP_CAID_BY_PID) || (op == OP_SLOT_BY_KEYS)) ? 3'd0 : slot;
    end else if (cmd.next_slot) begin
      slot_r <= slot_r + 3'd1;
    end
  end

  // issue stage
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      issued <= 1'b0;
    end else begin
      issued <= cmd.issue;
      if (cmd.load || cmd.start_scan) begin
        idx <= '0;
      end else if (cmd.issue) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    issued_idx <= idx_i;
    in_p_q     <= in_p;
    in_c_q     <= in_c;
    pid_v_q    <= in_p && pid_vld[pid_raddr];
    capid_v_q  <= in_p && capid_vld[pid_raddr];
    caid_v_q   <= in_c && caid_vld[caid_raddr];
  end

  // compare stage
  always_comb begin
    pid_val   = pid_v_q ? pid_q : 16'd0;
    caid_val  = caid_v_q ? caid_q : 16'd0;
    capid_val = capid_v_q ? capid_q : 16'd0;
    caid_key  = (op_r == OP_SLOT_BY_KEYS) ? key2_r : key_r;
    pid_eq    = in_p_q && (pid_val == key_r);
    caid_eq   = in_c_q && (caid_val == caid_key);
    capid_eq  = in_p_q && (capid_val == key_r);
    case (sel_r)
      LIST_PID: begin
        sel_eq   = pid_eq;
        sel_zero = in_p_q && (pid_val == 16'd0);
      end
      LIST_CAID: begin
        sel_eq   = caid_eq;
        sel_zero = in_c_q && (caid_val == 16'd0);
      end
      LIST_CAPID: begin
        sel_eq   = capid_eq;
        sel_zero = in_p_q && (capid_val == 16'd0);
      end
      default: begin
        sel_eq   = 1'b0;
        sel_zero = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pid_hit     <= 1'b0;
      caid_hit    <= 1'b0;
      sel_hit     <= 1'b0;
      empty_found <= 1'b0;
    end else if (cmd.load || cmd.start_scan) begin
      pid_hit     <= 1'b0;
      caid_hit    <= 1'b0;
      sel_hit     <= 1'b0;
      empty_found <= 1'b0;
    end else if (issued) begin
      if (pid_eq && !pid_hit) begin
        pid_hit <= 1'b1;
        pid_idx <= issued_idx;
      end
      if (caid_eq) begin
        caid_hit <= 1'b1;
      end
      if (sel_eq) begin
        sel_hit <= 1'b1;
      end
      if (sel_zero && !empty_found) begin
        empty_found <= 1'b1;
        empty_idx   <= issued_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issued && (issued_idx == '0)) begin
      caid_first <= caid_val;
    end
  end

  // valid bits: reset and clear drop whole rows, add sets, delete drops one
  always_ff @(posedge clk) begin
    if (rst) begin
      pid_vld   <= '0;
      caid_vld  <= '0;
      capid_vld <= '0;
    end else begin
      for (int j = 0; j < PID_DEPTH; j++) begin
        if (clr_pid && ((j / PID_ENTRIES) == int'(slot_r))) begin
          pid_vld[j] <= 1'b0;
        end
        if (clr_capid && ((j / PID_ENTRIES) == int'(slot_r))) begin
          capid_vld[j] <= 1'b0;
        end
      end
      for (int j = 0; j < CAID_DEPTH; j++) begin
        if (clr_caid && ((j / CAID_ENTRIES) == int'(slot_r))) begin
          caid_vld[j] <= 1'b0;
        end
      end
      if (pid_we) begin
        pid_vld[pid_waddr] <= 1'b1;
      end
      if (capid_we) begin
        capid_vld[pid_waddr] <= 1'b1;
      end
      if (caid_we) begin
        caid_vld[caid_waddr] <= 1'b1;
      end
      if (del_clr) begin
        pid_vld[del_addr] <= 1'b0;
      end
    end
  end

  // result
  always_comb begin
    status_next   = ST_OK;
    flag_next     = 1'b0;
    value_next    = 16'd0;
    slot_out_next = 3'd0;
    if (range_err) begin
      status_next = ST_BAD_SLOT;
    end else begin
      case (op_r)
        OP_FIND: flag_next = sel_hit;
        OP_ADD:  flag_next = add_ok;
        OP_DEL:  flag_next = pid_hit;
        OP_CAID_BY_PID: begin
          flag_next  = pid_hit;
          value_next = pid_hit ? caid_first : 16'd0;
        end
        OP_SLOT_BY_KEYS: begin
          if (pid_hit && caid_hit) begin
            flag_next     = 1'b1;
            slot_out_next = slot_r;
          end else begin
            status_next = ST_NO_MATCH;
          end
        end
        default: flag_next = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.capture) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      status    <= status_next;
      flag      <= flag_next;
      value_out <= value_next;
      slot_out  <= slot_out_next;
    end
  end

  always_comb begin
    stat.skip_scan  = range_err || (op_r == OP_CLEAR) || (op_r > OP_SLOT_BY_KEYS) ||
                      ((op_r == OP_CAID_BY_PID) && (key_r == 16'd0)) ||
                      (((op_r == OP_FIND) || (op_r == OP_ADD)) && (sel_r == LIST_ALL));
    stat.idx_last   = idx == CNT_W'(MAX_ENTRIES - 1);
    stat.multi_slot = (op_r == OP_CAID_BY_PID) || (op_r == OP_SLOT_BY_KEYS);
    stat.slot_done  = (op_r == OP_CAID_BY_PID) ? pid_hit : (pid_hit && caid_hit);
    stat.slot_last  = slot_r == SLOT_LAST;
    stat.out_free   = !rsp_valid || rsp_ready;
  end

endmodule

// ----- hdl/cspt_ctrl.sv -----
// ----------------------------------------------------------------------------
// cspt_ctrl
// Sequencer: decode, row scan, per-slot evaluation and result hand-off.
// ----------------------------------------------------------------------------
module cspt_ctrl import cspt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  cspt_stat_t stat,
  output cspt_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_SCAN   = 5'b00100,
    S_LAST   = 5'b01000,
    S_EVAL   = 5'b10000
  } state_t;

  state_t state, state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.skip_scan) begin
          if (stat.out_free) begin
            cmd.capture = 1'b1;
            state_next  = S_IDLE;
          end
        end else begin
          cmd.start_scan = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.idx_last) begin
          state_next = S_LAST;
        end
      end
      // last compare lands here
      S_LAST: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (stat.multi_slot && !stat.slot_done && !stat.slot_last) begin
          cmd.next_slot  = 1'b1;
          cmd.start_scan = 1'b1;
          state_next     = S_SCAN;
        end else if (stat.out_free) begin
          cmd.capture = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/ca_slot_pid_caid_table.sv -----
// ----------------------------------------------------------------------------
// ca_slot_pid_caid_table
// Per-slot PID, CA system id and CA PID tables for CA module slots.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                    | beat when
//  --------+-----+-------------------------------------------+------------------
//  req     | in  | op, slot, list_sel, key, second_key       | valid && ready
//  rsp     | out | status, flag, value_out, slot_out         | valid && ready
//
//  One request in flight. A scan of one slot reads all three list RAMs one
//  entry a cycle through their single read ports; cross-slot searches scan the
//  slots in turn from slot 0 until one matches or the last slot is done.
//  Requests that need no scan are answered straight from the decode state.
//  Reset clears the entry valid bits at once; no sweep.
//  A result waits in the output register; a new request is taken meanwhile
//  and stalls only at its own hand-off while rsp is not ready.
// ----------------------------------------------------------------------------
module ca_slot_pid_caid_table import cspt_pkg::*; (
  input logic        clk,
  input logic        rst,
  cspt_req_if.sink   req,
  cspt_rsp_if.source rsp
);

  cspt_cmd_t  cmd;
  cspt_stat_t stat;
  logic       ready_int;

  assign req.ready = ready_int;

  cspt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready_int),
    .stat      (stat),
    .cmd       (cmd)
  );

  cspt_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .op         (req.op),
    .slot       (req.slot),
    .list_sel   (req.list_sel),
    .key        (req.key),
    .second_key (req.second_key),
    .rsp_ready  (rsp.ready),
    .rsp_valid  (rsp.valid),
    .status     (rsp.status),
    .flag       (rsp.flag),
    .value_out  (rsp.value_out),
    .slot_out   (rsp.slot_out)
  );

endmodule

// ----- sim/tb_ca_slot_pid_caid_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ca_slot_pid_caid_table
// Self-checking bench for the CA slot PID/CAID table. A short directed list
// covers zero keys, bad slots, the all-lists selector and the spare opcodes.
// Random add/lookup/delete/clear runs over small key pools then fill the lists
// to full and empty them again. The bench keeps its own copy of the tables,
// predicts each response at request accept time, and checks every response
// beat in order under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_ca_slot_pid_caid_table;
  import cspt_pkg::*;

  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int POOL_SIZE  = 20;
  localparam int LONG_HOLD  = 400;
  localparam int TAIL_WAIT  = 150;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  slot;
    logic [1:0]  list_sel;
    logic [15:0] key;
    logic [15:0] second_key;
  } table_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        flag;
    logic [15:0] value_out;
    logic [2:0]  slot_out;
  } table_rsp_t;

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_RHYTHM} rx_mode_t;

  logic clk = 1'b0;
  logic rst;

  cspt_req_if req_bus ();
  cspt_rsp_if rsp_bus ();

  ca_slot_pid_caid_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the tables
  logic [15:0] pid_tab   [SLOT_COUNT][PID_ENTRIES];
  logic [15:0] caid_tab  [SLOT_COUNT][CAID_ENTRIES];
  logic [15:0] capid_tab [SLOT_COUNT][PID_ENTRIES];

  table_req_t req_pending_q [$];
  table_rsp_t rsp_expect_q  [$];
  table_req_t on_wire;
  table_req_t next_req;
  table_rsp_t want;

  int queued_count   = 0;
  int accepted_count = 0;
  int mismatch_count = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int hold_requests  = 0;
  int holds_taken    = 0;
  int rx_hold_left   = 0;
  int rx_mode_left   = 0;
  int rx_tick        = 0;
  rx_mode_t rx_mode  = RX_OPEN;

  logic [15:0] pid_pool  [POOL_SIZE];
  logic [15:0] caid_pool [POOL_SIZE];

  // ---------------------------------------------------------------- predictor
  function automatic int list_len(logic [1:0] sel);
    return (sel == LIST_CAID) ? CAID_ENTRIES : PID_ENTRIES;
  endfunction

  function automatic logic [15:0] entry_get(logic [1:0] sel, int s, int i);
    case (sel)
      LIST_PID:  return pid_tab[s][i];
      LIST_CAID: return caid_tab[s][i];
      default:   return capid_tab[s][i];
    endcase
  endfunction

  function automatic void entry_set(logic [1:0] sel, int s, int i, logic [15:0] v);
    case (sel)
      LIST_PID:  pid_tab[s][i] = v;
      LIST_CAID: caid_tab[s][i] = v;
      default:   capid_tab[s][i] = v;
    endcase
  endfunction

  // zero matches an empty entry, same as any other key
  function automatic bit list_holds(logic [1:0] sel, int s, logic [15:0] v);
    int i;
    for (i = 0; i < list_len(sel); i++)
      if (entry_get(sel, s, i) == v) return 1'b1;
    return 1'b0;
  endfunction

  function automatic table_rsp_t predict_table_op(table_req_t r);
    table_rsp_t o;
    int s;
    int i;
    bit done;
    o = '0;
    s = r.slot;
    done = 1'b0;
    if (r.op <= OP_CLEAR && r.slot >= SLOT_COUNT) begin
      o.status = ST_BAD_SLOT;
    end else begin
      case (r.op)
        OP_FIND: begin
          if (r.list_sel != LIST_ALL && list_holds(r.list_sel, s, r.key)) o.flag = 1'b1;
        end
        OP_ADD: begin
          if (r.list_sel != LIST_ALL && !list_holds(r.list_sel, s, r.key)) begin
            for (i = 0; i < list_len(r.list_sel) && !done; i++) begin
              if (entry_get(r.list_sel, s, i) == 16'd0) begin
                entry_set(r.list_sel, s, i, r.key);
                o.flag = 1'b1;
                done = 1'b1;
              end
            end
          end
        end
        OP_DEL: begin
          for (i = 0; i < PID_ENTRIES && !done; i++) begin
            if (pid_tab[s][i] == r.key) begin
              pid_tab[s][i] = 16'd0;
              o.flag = 1'b1;
              done = 1'b1;
            end
          end
        end
        OP_CLEAR: begin
          for (i = 0; i < PID_ENTRIES; i++) begin
            if (r.list_sel == LIST_PID || r.list_sel == LIST_ALL) pid_tab[s][i] = 16'd0;
            if (r.list_sel == LIST_CAPID || r.list_sel == LIST_ALL) capid_tab[s][i] = 16'd0;
          end
          for (i = 0; i < CAID_ENTRIES; i++)
            if (r.list_sel == LIST_CAID || r.list_sel == LIST_ALL) caid_tab[s][i] = 16'd0;
        end
        OP_CAID_BY_PID: begin
          if (r.key != 16'd0) begin
            for (i = 0; i < SLOT_COUNT && !done; i++) begin
              if (list_holds(LIST_PID, i, r.key)) begin
                o.value_out = caid_tab[i][0];
                o.flag = 1'b1;
                done = 1'b1;
              end
            end
          end
        end
        OP_SLOT_BY_KEYS: begin
          o.status = ST_NO_MATCH;
          for (i = 0; i < SLOT_COUNT && !done; i++) begin
            if (list_holds(LIST_PID, i, r.key) && list_holds(LIST_CAID, i, r.second_key)) begin
              o.status = ST_OK;
              o.flag = 1'b1;
              o.slot_out = 3'(i);
              done = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    return o;
  endfunction

  // ---------------------------------------------------------------- stimulus
  task automatic queue_req(logic [2:0] op, logic [2:0] slot, logic [1:0] sel,
                           logic [15:0] key, logic [15:0] key2);
    table_req_t r;
    r.op = op;
    r.slot = slot;
    r.list_sel = sel;
    r.key = key;
    r.second_key = key2;
    req_pending_q.push_back(r);
    queued_count++;
  endtask

  // mostly valid slots, now and then any 3-bit value
  function automatic logic [2:0] pick_slot();
    if ($urandom_range(0, 9) == 0) return 3'($urandom_range(0, 7));
    return 3'($urandom_range(0, SLOT_COUNT - 1));
  endfunction

  function automatic logic [15:0] pick_pid();
    return pid_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [15:0] pick_caid();
    return caid_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // runs of related commands over small key pools, so lists fill up and drain
  task automatic queue_random_items(int target);
    int made;
    int n;
    int k;
    int kind;
    logic [2:0] s;
    logic [1:0] sel;
    logic [15:0] v;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        s = pick_slot();
        sel = ($urandom_range(0, 19) == 0) ? LIST_ALL : 2'($urandom_range(0, 2));
        n = $urandom_range(3, 18);
        for (k = 0; k < n; k++) begin
          v = (sel == LIST_CAID) ? pick_caid() : pick_pid();
          if ($urandom_range(0, 24) == 0) v = 16'd0;
          queue_req(OP_ADD, s, sel, v, 16'($urandom));
        end
      end else if (kind < 65) begin
        n = $urandom_range(2, 8);
        for (k = 0; k < n; k++) begin
          case ($urandom_range(0, 2))
            0: begin
              sel = 2'($urandom_range(0, 3));
              v = (sel == LIST_CAID) ? pick_caid() : pick_pid();
              queue_req(OP_FIND, pick_slot(), sel, v, 16'($urandom));
            end
            1: queue_req(OP_CAID_BY_PID, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                         ($urandom_range(0, 9) == 0) ? 16'd0 : pick_pid(), 16'($urandom));
            default: queue_req(OP_SLOT_BY_KEYS, 3'($urandom_range(0, 7)),
                               2'($urandom_range(0, 3)), pick_pid(),
                               ($urandom_range(0, 9) == 0) ? 16'd0 : pick_caid());
          endcase
        end
        n = n;
      end else if (kind < 80) begin
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++)
          queue_req(OP_DEL, pick_slot(), 2'($urandom_range(0, 3)),
                    ($urandom_range(0, 9) == 0) ? 16'd0 : pick_pid(), 16'($urandom));
      end else if (kind < 85) begin
        n = 1;
        queue_req(OP_CLEAR, pick_slot(), 2'($urandom_range(0, 3)), 16'($urandom),
                  16'($urandom));
      end else begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
          queue_req(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
      end
      made += n;
    end
  endtask

  task automatic wait_drained();
    while (accepted_count != queued_count || rsp_expect_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        rsp_expect_q.push_back(predict_table_op(on_wire));
        accepted_count++;
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_bus.valid <= 1'b0;
        end else if (req_pending_q.size() > 0) begin
          next_req = req_pending_q.pop_front();
          on_wire = next_req;
          req_bus.op <= next_req.op;
          req_bus.slot <= next_req.slot;
          req_bus.list_sel <= next_req.list_sel;
          req_bus.key <= next_req.key;
          req_bus.second_key <= next_req.second_key;
          req_bus.valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      rx_tick = 0;
    end else begin
      rx_tick++;
      if (hold_requests != holds_taken) begin
        holds_taken++;
        rx_hold_left = LONG_HOLD;
      end
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 120);
      end else begin
        rx_mode_left--;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   rsp_bus.ready <= 1'b1;
          RX_HALF:   rsp_bus.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
          default:   rsp_bus.ready <= (rx_tick % 3 != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (rsp_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] unexpected response beat: status=%0d flag=%0d value=%h slot=%0d",
                   $realtime, rsp_bus.status, rsp_bus.flag, rsp_bus.value_out,
                   rsp_bus.slot_out);
      end else begin
        want = rsp_expect_q.pop_front();
        if (rsp_bus.status !== want.status || rsp_bus.flag !== want.flag ||
            rsp_bus.value_out !== want.value_out || rsp_bus.slot_out !== want.slot_out) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] mismatch: exp status=%0d flag=%0d value=%h slot=%0d, got status=%0d flag=%0d value=%h slot=%0d",
                     $realtime, want.status, want.flag, want.value_out, want.slot_out,
                     rsp_bus.status, rsp_bus.flag, rsp_bus.value_out, rsp_bus.slot_out);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int i;
    int s;
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.op = '0;
    req_bus.slot = '0;
    req_bus.list_sel = '0;
    req_bus.key = '0;
    req_bus.second_key = '0;
    rsp_bus.ready = 1'b0;
    for (s = 0; s < SLOT_COUNT; s++) begin
      for (i = 0; i < PID_ENTRIES; i++) begin
        pid_tab[s][i] = 16'd0;
        capid_tab[s][i] = 16'd0;
      end
      for (i = 0; i < CAID_ENTRIES; i++) caid_tab[s][i] = 16'd0;
    end
    for (i = 0; i < POOL_SIZE; i++) begin
      pid_pool[i] = 16'($urandom_range(1, 65535));
      caid_pool[i] = 16'($urandom_range(1, 65535));
    end
    pid_pool[0] = 16'hFFFF;
    caid_pool[0] = 16'hFFFF;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty table: zero key finds an empty entry
    queue_req(OP_FIND, 3'd0, LIST_PID, 16'h0000, 16'h0000);
    queue_req(OP_ADD, 3'd0, LIST_PID, 16'hFFFF, 16'h0000);
    queue_req(OP_ADD, 3'd0, LIST_PID, 16'hFFFF, 16'h0000);
    queue_req(OP_ADD, 3'd0, LIST_PID, 16'h0000, 16'h0000);
    queue_req(OP_ADD, 3'd0, LIST_CAID, 16'h0001, 16'h0000);
    queue_req(OP_ADD, 3'd0, LIST_CAPID, 16'h8000, 16'h0000);
    queue_req(OP_FIND, 3'd0, LIST_CAPID, 16'h8000, 16'h0000);
    // all-lists selector only means something to clear
    queue_req(OP_FIND, 3'd0, LIST_ALL, 16'hFFFF, 16'h0000);
    queue_req(OP_ADD, 3'd0, LIST_ALL, 16'h1234, 16'h0000);
    queue_req(OP_CAID_BY_PID, 3'd6, LIST_CAPID, 16'hFFFF, 16'hFFFF);
    queue_req(OP_CAID_BY_PID, 3'd0, LIST_PID, 16'h0000, 16'h0000);
    queue_req(OP_ADD, 3'(SLOT_COUNT - 1), LIST_PID, 16'h7FFE, 16'h0000);
    // zero CA id matches an empty caid entry of the last slot
    queue_req(OP_SLOT_BY_KEYS, 3'd7, LIST_ALL, 16'h7FFE, 16'h0000);
    queue_req(OP_SLOT_BY_KEYS, 3'd0, LIST_PID, 16'hFFFF, 16'h0001);
    queue_req(OP_SLOT_BY_KEYS, 3'd0, LIST_PID, 16'h5555, 16'hAAAA);
    queue_req(OP_FIND, 3'(SLOT_COUNT), LIST_PID, 16'hFFFF, 16'h0000);
    queue_req(OP_ADD, 3'd7, LIST_CAID, 16'h4321, 16'h0000);
    queue_req(OP_DEL, 3'd4, LIST_PID, 16'hFFFF, 16'h0000);
    queue_req(OP_CLEAR, 3'd5, LIST_ALL, 16'h0000, 16'h0000);
    queue_req(OP_DEL, 3'd0, LIST_CAID, 16'h0000, 16'h0000);
    queue_req(OP_DEL, 3'd0, LIST_PID, 16'hFFFF, 16'h0000);
    queue_req(OP_CLEAR, 3'd0, LIST_ALL, 16'hFFFF, 16'hFFFF);
    queue_req(OP_CLEAR, 3'(SLOT_COUNT - 1), LIST_CAID, 16'h0000, 16'h0000);
    queue_req(OP_UNUSED_LO, 3'd7, LIST_ALL, 16'hFFFF, 16'hFFFF);
    queue_req(OP_UNUSED_HI, 3'd0, LIST_PID, 16'hA5A5, 16'h5A5A);
    wait_drained();

    // long receiver hold while the sender keeps offering
    queue_random_items(800);
    hold_requests <= hold_requests + 1;
    wait_drained();

    // sender was idle until everything came back
    queue_random_items(800);
    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);

    if (mismatch_count == 0 && rsp_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
